@@ src/ccr_pkg.sv @@
package ccr_pkg;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_OK        = 1'b0,
        ST_NO_POINTS = 1'b1
    } status_t;

    localparam int CoordW = 32;
    localparam int TW     = 16;
    localparam int CountW = 7;
    localparam int IdxW   = 6;
    // Working width of the Horner terms (points times small basis factors).
    localparam int AccW   = 40;

    localparam logic [3:0] ADDR_POINT_COUNT = 4'd0;

    typedef struct packed
    {
        op_t                      operation;
        logic [IdxW-1:0]          point_index;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic [TW-1:0]            curve_t;
    } in_word_t;

    typedef struct packed
    {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic signed [CoordW-1:0] slope_x;
        logic signed [CoordW-1:0] slope_y;
        logic signed [CoordW-1:0] slope_z;
        status_t                  status;
    } out_word_t;

    // floor(v / 65536) of a signed product; an arithmetic shift is exactly that.
    function automatic logic signed [AccW-1:0] floor16(input logic signed [AccW+TW:0] v);
        logic signed [AccW+TW:0] s;
        begin
            s = v >>> TW;
            return s[AccW-1:0];
        end
    endfunction

    // floor((s+1)/2) saturated to 32 bits signed.
    function automatic logic signed [CoordW-1:0] half_sat(input logic signed [AccW-1:0] s);
        logic signed [AccW:0] w;
        logic signed [AccW:0] h;
        begin
            w = {s[AccW-1], s} + (AccW+1)'(1);
            h = w >>> 1;
            if (h > (AccW+1)'(signed'(32'sh7fffffff)))
                return 32'sh7fffffff;
            else if (h < -(AccW+1)'(signed'(33'sh080000000)))
                return 32'sh80000000;
            else
                return h[CoordW-1:0];
        end
    endfunction

endpackage

@@ src/ccr_stream_if.sv @@
interface ccr_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ccr_ram.sv @@
module ccr_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ src/ccr_axis.sv @@
// One axis of the cubic: takes the four points after they are collected,
// forms the basis terms and runs Horner over registered stages.
module ccr_axis (
    input  logic                                   clk,
    input  logic [6:0]                             adv,
    input  logic signed [ccr_pkg::CoordW-1:0]      p0,
    input  logic signed [ccr_pkg::CoordW-1:0]      p1,
    input  logic signed [ccr_pkg::CoordW-1:0]      p2,
    input  logic signed [ccr_pkg::CoordW-1:0]      p3,
    input  logic [ccr_pkg::TW-1:0]                 u,
    output logic signed [ccr_pkg::CoordW-1:0]      pos,
    output logic signed [ccr_pkg::CoordW-1:0]      slope
);
    import ccr_pkg::*;

    localparam int PW = AccW + TW + 1;

    logic signed [AccW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [AccW-1:0] pa_reg, pb_reg, pc_reg, pd2_reg;
    logic signed [AccW-1:0] sa_reg, sb_reg, sc_reg;
    logic signed [PW-1:0]   pm_reg, sm_reg;
    logic signed [AccW-1:0] ps_reg, ss_reg;
    logic signed [AccW-1:0] e0, e1, e2, e3;
    logic signed [PW-1:0]   us;

    assign e0 = AccW'(p0);
    assign e1 = AccW'(p1);
    assign e2 = AccW'(p2);
    assign e3 = AccW'(p3);
    assign us = PW'($signed({1'b0, u}));

    // Stage 0: basis coefficients (doubled, as in the exact form).
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg <= -e0 + 3 * e1 - 3 * e2 + e3;
            b_reg <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
            c_reg <= e2 - e0;
            d_reg <= 2 * e1;
        end
    end

    // Stages 1..6: a multiply by u alternates with a shift and add, position and slope
    // in parallel until the slope is complete; the position needs one more round.
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pm_reg <= PW'(a_reg) * us;
            sm_reg <= PW'(3 * a_reg) * us;
            pb_reg <= b_reg;
            pc_reg <= c_reg;
            pd2_reg <= d_reg;
            sb_reg <= 2 * b_reg;
            sc_reg <= c_reg;
        end
        if (adv[2])
        begin
            ps_reg <= floor16(pm_reg) + pb_reg;
            ss_reg <= floor16(sm_reg) + sb_reg;
            pa_reg <= pc_reg;
            sa_reg <= sc_reg;
        end
        if (adv[3])
        begin
            pm_reg <= PW'(ps_reg) * us;
            sm_reg <= PW'(ss_reg) * us;
        end
        if (adv[4])
        begin
            ps_reg <= floor16(pm_reg) + pa_reg;
            ss_reg <= floor16(sm_reg) + sa_reg;
        end
        if (adv[5])
            pm_reg <= PW'(ps_reg) * us;
        if (adv[6])
            ps_reg <= floor16(pm_reg) + pd2_reg;
    end

    assign pos   = half_sat(ps_reg);
    assign slope = half_sat(ss_reg);
endmodule

@@ src/closed_catmull_rom_evaluator.sv @@
// Closed-loop Catmull-Rom evaluator. Control points live in three single-port
// RAMs (x, y, z) of MAX_POINTS words. A load word writes one slot and gives no
// result; an evaluate word scales curve_t by point_count, reads the four
// neighboring points one per cycle from the RAMs (wrapping around the loop),
// then runs the cubic through a registered multiply chain. The core runs one
// evaluate at a time: the reads, seven arithmetic stages and the step that
// fills the output register keep it busy, and no word is taken until it
// finishes. With no points in use an evaluate skips the arithmetic and
// finishes in its first step once the output register is free. Loads are
// taken every cycle while no evaluate runs. A finished result waits in the
// output register while later words are taken; a following evaluate holds in
// its last step until that register is free. A point_count above MAX_POINTS
// acts as MAX_POINTS; loads beyond the table are dropped.
module closed_catmull_rom_evaluator #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ccr_stream_if.sink   in_ch,
    ccr_stream_if.source out_ch
);
    import ccr_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    // Configuration.
    logic [CountW-1:0] point_count_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_POINT_COUNT[1:0]) ? 32'(point_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= '0;
        else if (psel && penable && pwrite && paddr == ADDR_POINT_COUNT[1:0])
            point_count_reg <= pwdata[CountW-1:0];
    end

    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (32'(point_count_reg) > 32'(MAX_POINTS))
            n_eff = NW'(MAX_POINTS);
        else
            n_eff = NW'(point_count_reg);
    end

    // Sequencer: busy for the duration of one evaluate (read + pipe).
    localparam int SeqLen = 12;
    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;
    logic [TW-1:0] u_reg;
    logic [AW-1:0] rd_idx_reg;
    logic        zero_reg;
    in_word_t    iw;

    assign iw = in_ch.data;
    assign in_ch.ready = !busy_reg;

    logic take, take_eval, take_load;
    assign take      = in_ch.valid && in_ch.ready;
    assign take_eval = take && iw.operation == OP_EVAL;
    assign take_load = take && iw.operation == OP_LOAD;

    // The last step hands the result to the output register once that
    // register is empty or being read in the same cycle.
    logic last_step, out_free, finish;
    assign last_step = zero_reg || step_reg == 4'(SeqLen - 1);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign finish    = busy_reg && last_step && out_free;

    // Segment and fraction.
    logic [TW+NW-1:0] scaled;
    logic [AW-1:0]    start_idx;
    logic [NW:0]      tmp_idx;
    assign scaled  = (TW+NW)'(iw.curve_t) * (TW+NW)'(n_eff);
    assign tmp_idx = (NW+1)'(scaled[TW+NW-1:TW]) + (NW+1)'(n_eff) - (NW+1)'(1);
    assign start_idx = (tmp_idx >= (NW+1)'(n_eff)) ? AW'(tmp_idx - (NW+1)'(n_eff))
                                                   : AW'(tmp_idx);

    logic [AW-1:0] next_idx;
    assign next_idx = ((NW)'(rd_idx_reg) + NW'(1) >= n_eff) ? '0 : AW'(rd_idx_reg + AW'(1));

    // RAM access: load writes, evaluate reads.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [CoordW-1:0] rx, ry, rz;
    assign ram_we   = take_load && 32'(iw.point_index) < 32'(MAX_POINTS);
    assign ram_addr = take ? (take_load ? AW'(iw.point_index) : start_idx) : rd_idx_reg;

    ccr_ram #(.Width(CoordW), .Depth(MAX_POINTS)) u_ram_x
        (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(iw.coord_x), .rdata(rx));
    ccr_ram #(.Width(CoordW), .Depth(MAX_POINTS)) u_ram_y
        (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(iw.coord_y), .rdata(ry));
    ccr_ram #(.Width(CoordW), .Depth(MAX_POINTS)) u_ram_z
        (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(iw.coord_z), .rdata(rz));

    // Point window: read data shifts in through four registers.
    logic signed [CoordW-1:0] wx_reg [4];
    logic signed [CoordW-1:0] wy_reg [4];
    logic signed [CoordW-1:0] wz_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else if (take_eval)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (finish)
                busy_reg <= 1'b0;
            else if (!last_step)
                step_reg <= step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_eval)
        begin
            u_reg      <= scaled[TW-1:0];
            zero_reg   <= n_eff == '0;
            rd_idx_reg <= (start_idx + AW'(1) >= AW'(n_eff) && n_eff <= NW'(MAX_POINTS)
                           && 32'(start_idx) + 1 >= 32'(n_eff)) ? '0 : AW'(start_idx + AW'(1));
        end
        else if (busy_reg && step_reg < 4'd3)
            rd_idx_reg <= next_idx;
        if (busy_reg && step_reg < 4'd4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wx_reg[i] <= wx_reg[i+1];
                wy_reg[i] <= wy_reg[i+1];
                wz_reg[i] <= wz_reg[i+1];
            end
            wx_reg[3] <= rx;
            wy_reg[3] <= ry;
            wz_reg[3] <= rz;
        end
    end

    // Stage enables of the arithmetic chain.
    logic [6:0] adv;
    always_comb
    begin
        for (int i = 0; i < 7; i++)
            adv[i] = busy_reg && step_reg == 4'(4 + i);
    end

    logic signed [CoordW-1:0] px, py, pz, sx, sy, sz;
    ccr_axis u_ax (.clk(clk), .adv(adv), .p0(wx_reg[0]), .p1(wx_reg[1]), .p2(wx_reg[2]),
                   .p3(wx_reg[3]), .u(u_reg), .pos(px), .slope(sx));
    ccr_axis u_ay (.clk(clk), .adv(adv), .p0(wy_reg[0]), .p1(wy_reg[1]), .p2(wy_reg[2]),
                   .p3(wy_reg[3]), .u(u_reg), .pos(py), .slope(sy));
    ccr_axis u_az (.clk(clk), .adv(adv), .p0(wz_reg[0]), .p1(wz_reg[1]), .p2(wz_reg[2]),
                   .p3(wz_reg[3]), .u(u_reg), .pos(pz), .slope(sz));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (zero_reg)
                out_reg <= '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ST_NO_POINTS};
            else
                out_reg <= '{px, py, pz, sx, sy, sz, ST_OK};
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // A new evaluate never starts while one is in progress.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !take)
        else $error("word taken while busy");

    // A result is only produced by a running evaluate.
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("result without evaluate");

    // A waiting result is not overwritten.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !finish)
        else $error("result overwritten");
endmodule

@@ dv/tb_closed_catmull_rom_evaluator.sv @@
module tb_closed_catmull_rom_evaluator;
    import ccr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The stall watchdog counts cycles in which no word moves on either
    // channel. The limit lies far above the longest evaluate and the longest
    // random gap on either side.
    localparam int StallLimit = 5000;
    localparam int RandomWords = 1550;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ccr_stream_if #(.word_t(in_word_t)) in_ch ();
    ccr_stream_if #(.word_t(out_word_t)) out_ch ();

    closed_catmull_rom_evaluator dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #10 clk = ~clk;

    // The spline predictor keeps its own copy of the point tables and the
    // point count, and queues the word that each evaluate should return.
    class spline_scoreboard;
        logic signed [31:0] tab_x [64];
        logic signed [31:0] tab_y [64];
        logic signed [31:0] tab_z [64];
        int unsigned count_in_use;
        out_word_t pending [$];
        int errors;
        int evals_checked;
        int loads_seen;

        function automatic longint fl16(longint v);
            return v >>> 16;
        endfunction

        function automatic logic signed [31:0] halve_sat(longint s);
            longint h;
            h = (s + 1) >>> 1;
            if (h > 64'sd2147483647)
                return 32'sh7fffffff;
            if (h < -64'sd2147483648)
                return 32'sh80000000;
            return h[31:0];
        endfunction

        // Horner form of the basis with coefficients at twice their size.
        function automatic void spline_axis(input longint p0, input longint p1,
                                            input longint p2, input longint p3,
                                            input longint u,
                                            output logic signed [31:0] pos,
                                            output logic signed [31:0] slope);
            longint a;
            longint b;
            longint c;
            longint s;
            a = -p0 + 3 * p1 - 3 * p2 + p3;
            b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c = p2 - p0;
            s = fl16(a * u) + b;
            s = fl16(s * u) + c;
            s = fl16(s * u) + 2 * p1;
            pos = halve_sat(s);
            s = fl16(3 * a * u) + 2 * b;
            s = fl16(s * u) + c;
            slope = halve_sat(s);
        endfunction

        function void note_word(in_word_t w);
            out_word_t r;
            int unsigned n;
            int unsigned scaled;
            int unsigned seg;
            int unsigned idx [4];
            if (w.operation == OP_LOAD)
            begin
                tab_x[w.point_index] = w.coord_x;
                tab_y[w.point_index] = w.coord_y;
                tab_z[w.point_index] = w.coord_z;
                loads_seen++;
                return;
            end
            r = '0;
            n = (count_in_use > 64) ? 64 : count_in_use;
            if (n == 0)
            begin
                r.status = ST_NO_POINTS;
                pending.push_back(r);
                return;
            end
            scaled = w.curve_t * n;
            seg = scaled >> 16;
            idx[0] = (seg + n - 1) % n;
            for (int k = 1; k < 4; k++)
                idx[k] = (idx[k-1] + 1) % n;
            spline_axis(tab_x[idx[0]], tab_x[idx[1]], tab_x[idx[2]], tab_x[idx[3]],
                        scaled & 16'hffff, r.pos_x, r.slope_x);
            spline_axis(tab_y[idx[0]], tab_y[idx[1]], tab_y[idx[2]], tab_y[idx[3]],
                        scaled & 16'hffff, r.pos_y, r.slope_y);
            spline_axis(tab_z[idx[0]], tab_z[idx[1]], tab_z[idx[2]], tab_z[idx[3]],
                        scaled & 16'hffff, r.pos_z, r.slope_z);
            r.status = ST_OK;
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_word(out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            want = pending.pop_front();
            evals_checked++;
            if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
            if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
            if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
            if (got.slope_x !== want.slope_x) report("slope_x", got.slope_x, want.slope_x);
            if (got.slope_y !== want.slope_y) report("slope_y", got.slope_y, want.slope_y);
            if (got.slope_z !== want.slope_z) report("slope_z", got.slope_z, want.slope_z);
            if (got.status !== want.status) report("status", got.status, want.status);
        endtask
    endclass

    spline_scoreboard board = new();
    int stall_cycles = 0;
    bit sink_calm = 1'b0;

    // A gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Accepted words are sampled at the clock edge; the scoreboard sees the
    // values that were on the channels just before it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_word(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                board.check_word(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= StallLimit)
        begin
            $display("watchdog: no progress for %0d cycles", StallLimit);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: ready toggles at random, with calm stretches held high.
    initial
    begin
        int hold;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ch.ready <= 1'b1;
            hold = sink_calm ? 1 : $urandom_range(1, 8);
            repeat (hold) @(posedge clk);
            if (!sink_calm)
            begin
                hold = gap_len();
                if (hold > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
        end
    end

    // Writes the point count through the APB port: setup, then access.
    task write_count(int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_POINT_COUNT[1:0];
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.count_in_use = value & 7'h7f;
    endtask

    // Waits until every evaluate has come back, plus the pipeline depth.
    task drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Sends one word, with an optional random gap before it. Valid is only
    // lowered when a gap follows, so it never drops and rises in one step.
    task send_word(in_word_t w, bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] coord_pick(int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_word_t load_word(int slot, int mode);
        in_word_t w;
        w = '0;
        w.operation = OP_LOAD;
        w.point_index = IdxW'(slot);
        w.coord_x = coord_pick(mode == 4 ? $urandom_range(0, 3) : mode);
        w.coord_y = coord_pick(mode == 4 ? $urandom_range(0, 3) : mode);
        w.coord_z = coord_pick(mode == 4 ? $urandom_range(0, 3) : mode);
        w.curve_t = TW'($urandom);
        return w;
    endfunction

    function automatic in_word_t eval_word(logic [15:0] t);
        in_word_t w;
        w = '0;
        w.operation = OP_EVAL;
        w.point_index = IdxW'($urandom);
        w.coord_x = $urandom;
        w.coord_y = $urandom;
        w.coord_z = $urandom;
        w.curve_t = t;
        return w;
    endfunction

    // Every slot is loaded before anything uses it, so no evaluate ever reads
    // an unwritten entry regardless of the count in force.
    task fill_table(int mode, bit with_gaps);
        for (int s = 0; s < 64; s++)
            send_word(load_word(s, mode), with_gaps);
    endtask

    initial
    begin
        int counts [6];
        int sent;
        int phase;
        int mode;
        in_word_t w;

        in_ch.valid = 1'b0;
        in_ch.data = '0;
        counts = '{1, 4, 64, 100, 127, 3};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With no points in use, evaluates report that status.
        sink_calm = 1'b1;
        send_word(eval_word(16'h0000), 1'b0);
        send_word(eval_word(16'hffff), 1'b0);
        fill_table(0, 1'b0);
        stop_sending();
        drain();
        write_count(4);
        send_word(eval_word(16'h0000), 1'b0);
        send_word(eval_word(16'hffff), 1'b0);
        send_word(eval_word(16'h8000), 1'b0);
        // One minimum among maximum points pushes every axis into saturation.
        send_word(load_word(1, 1), 1'b0);
        send_word(eval_word(16'h3fff), 1'b0);
        send_word(eval_word(16'h4000), 1'b0);
        send_word(eval_word(16'h7123), 1'b0);
        stop_sending();
        drain();
        // A count above the table behaves as a full table.
        write_count(127);
        send_word(eval_word(16'hffff), 1'b0);
        send_word(eval_word(16'h0001), 1'b0);
        stop_sending();
        drain();
        write_count(0);
        send_word(eval_word(16'h1234), 1'b0);
        stop_sending();
        drain();
        sink_calm = 1'b0;

        // Random part in phases, each with its own count and coordinate style.
        sent = 0;
        phase = 0;
        while (sent < RandomWords)
        begin
            write_count(phase < 6 ? counts[phase] : $urandom_range(0, 127));
            mode = $urandom_range(2, 4);
            sink_calm = (phase % 4 == 3);
            fill_table(mode, phase % 4 != 3);
            for (int i = 0; i < 200; i++)
            begin
                if ($urandom_range(0, 99) < 30)
                    w = load_word($urandom_range(0, 63), mode);
                else
                    w = eval_word(TW'($urandom));
                send_word(w, phase % 4 != 3);
            end
            sent += 264;
            stop_sending();
            drain();
            phase++;
        end

        $display("covered %0d loads and %0d evaluates over %0d count settings",
                 board.loads_seen, board.evals_checked, phase + 4);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
